>>> rtl/core/trvg_pkg.sv
// Shared types and constants for the trail ribbon vertex generator.
package trvg_pkg;

  localparam logic [15:0] DEFAULT_LIMIT = 16'd20;
  localparam logic [16:0] FADE_ONE      = 17'h10000;

  localparam logic CFG_SEG_LIMIT  = 1'b0;
  localparam logic CFG_HALF_WIDTH = 1'b1;

  typedef struct packed {
    logic [31:0] p0_x;
    logic [31:0] p0_y;
    logic [31:0] p0_z;
    logic [31:0] p1_x;
    logic [31:0] p1_y;
    logic [31:0] p1_z;
    logic [15:0] seg;
    logic [15:0] n;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQ_A,
    ST_SQ_B,
    ST_ROOT,
    ST_MULW,
    ST_DIV,
    ST_EMIT
  } back_state_t;

endpackage

>>> rtl/core/trvg_front.sv
// Front end: accepts points, tracks the open line and queues segment jobs.
module trvg_front import trvg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic               first_of_line,
  input  logic [15:0]        line_points,
  input  logic [15:0]        segment_limit,
  output logic               push,
  output job_t               job
);

  logic [31:0] prev_x_r, prev_y_r, prev_z_r;
  logic [15:0] seg_r, piu_r;
  logic        active_r;
  logic [15:0] lim;
  logic [15:0] n_new;
  logic [16:0] seg_inc;
  logic [16:0] seg_inc2;
  logic        emit;

  assign lim      = (segment_limit != 16'd0) ? segment_limit : DEFAULT_LIMIT;
  assign n_new    = (line_points < lim) ? line_points : lim;
  assign seg_inc  = {1'b0, seg_r} + 17'd1;
  assign seg_inc2 = {1'b0, seg_r} + 17'd2;
  assign emit     = active_r && (piu_r >= 16'd2) && (seg_inc < {1'b0, piu_r});
  assign push     = accept && !first_of_line && emit;

  always_comb begin
    job.p0_x = prev_x_r;
    job.p0_y = prev_y_r;
    job.p0_z = prev_z_r;
    job.p1_x = pos_x;
    job.p1_y = pos_y;
    job.p1_z = pos_z;
    job.seg  = seg_r;
    job.n    = piu_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      prev_z_r <= '0;
      seg_r    <= '0;
      piu_r    <= '0;
      active_r <= 1'b0;
    end else if (accept) begin
      if (first_of_line) begin
        prev_x_r <= pos_x;
        prev_y_r <= pos_y;
        prev_z_r <= pos_z;
        seg_r    <= '0;
        piu_r    <= n_new;
        active_r <= (n_new >= 16'd2);
      end else if (emit) begin
        prev_x_r <= pos_x;
        prev_y_r <= pos_y;
        prev_z_r <= pos_z;
        seg_r    <= seg_inc[15:0];
        if (seg_inc2 >= {1'b0, piu_r}) begin
          active_r <= 1'b0;
        end
      end
    end
  end

endmodule

>>> rtl/core/trvg_fifo.sv
// Two-entry job queue between front and back.
module trvg_fifo import trvg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t rd_job,
  output logic not_empty,
  output logic full
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign rd_job    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

>>> rtl/core/trvg_div.sv
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor.
module trvg_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient,
  output logic        done
);

  logic [31:0] rem_r;
  logic [63:0] dvd_r;
  logic [31:0] dsr_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] t;
  logic [32:0] diff;
  logic        ge;

  assign t        = {rem_r, dvd_r[63]};
  assign diff     = t - {1'b0, dsr_r};
  assign ge       = (t >= {1'b0, dsr_r});
  assign quotient = dvd_r[31:0];
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : t[31:0];
      dvd_r <= {dvd_r[62:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/trvg_back.sv
// Back end: side vector, fades and six-vertex emission per segment.
module trvg_back import trvg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [30:0]        half_width,
  input  logic               job_valid,
  input  job_t               job_in,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_vert_x,
  output logic signed [31:0] out_vert_y,
  output logic signed [31:0] out_vert_z,
  output logic               out_tex_u,
  output logic [16:0]        out_fade,
  output logic               out_last_of_quad
);

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [32:0] ax_r, az_r;
  logic        dx_neg_r, dz_pos_r, zero_r;
  logic [63:0] sum_r, rt_rem_r, rt_res_r, rt_bit_r;
  logic [31:0] wx_r, wz_r;
  logic [16:0] f0_r, f1_r;
  logic [2:0]  vcnt_r;

  logic signed [32:0] dx, dz;
  logic [32:0] m;
  logic [61:0] sq;
  logic [63:0] rt_try;
  logic        rt_ge;
  logic [61:0] px, pz;
  logic [63:0] dvd_x, dvd_z, dvd_f0, dvd_f1;
  logic [16:0] k1;
  logic        div_start;
  logic [31:0] qx, qz, qf0, qf1;
  logic        dx_done, dz_done, f0_done, f1_done;
  logic        out_fire;
  logic        plus, far;
  logic [31:0] bx, by, bz;

  assign dx  = $signed({job_in.p1_x[31], job_in.p1_x}) - $signed({job_in.p0_x[31], job_in.p0_x});
  assign dz  = $signed({job_in.p1_z[31], job_in.p1_z}) - $signed({job_in.p0_z[31], job_in.p0_z});
  assign m   = (ax_r > az_r) ? ax_r : az_r;
  assign sq  = (state_r == ST_SQ_A) ? ax_r[30:0] * ax_r[30:0] : az_r[30:0] * az_r[30:0];
  assign rt_try = rt_res_r + rt_bit_r;
  assign rt_ge  = (rt_rem_r >= rt_try);

  assign px     = half_width * az_r[30:0];
  assign pz     = half_width * ax_r[30:0];
  assign dvd_x  = {2'b0, px} + {33'b0, rt_res_r[31:1]};
  assign dvd_z  = {2'b0, pz} + {33'b0, rt_res_r[31:1]};
  assign k1     = {1'b0, job_r.seg} + 17'd1;
  assign dvd_f0 = {32'b0, job_r.seg, 16'b0} + {49'b0, job_r.n[15:1]};
  assign dvd_f1 = {31'b0, k1, 16'b0} + {49'b0, job_r.n[15:1]};
  assign div_start = (state_r == ST_MULW);

  trvg_div u_div_x (.clk, .rst_n, .start(div_start), .dividend(dvd_x),
    .divisor(rt_res_r[31:0]), .quotient(qx), .done(dx_done));
  trvg_div u_div_z (.clk, .rst_n, .start(div_start), .dividend(dvd_z),
    .divisor(rt_res_r[31:0]), .quotient(qz), .done(dz_done));
  trvg_div u_div_f0 (.clk, .rst_n, .start(div_start), .dividend(dvd_f0),
    .divisor({16'b0, job_r.n}), .quotient(qf0), .done(f0_done));
  trvg_div u_div_f1 (.clk, .rst_n, .start(div_start), .dividend(dvd_f1),
    .divisor({16'b0, job_r.n}), .quotient(qf1), .done(f1_done));

  assign out_fire = out_valid && !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (job_valid) state_nxt = ST_NORM;
      ST_NORM: begin
        if (m == 33'd0) state_nxt = ST_MULW;
        else if (!m[32] && !m[31] && m[30]) state_nxt = ST_SQ_A;
      end
      ST_SQ_A: state_nxt = ST_SQ_B;
      ST_SQ_B: state_nxt = ST_ROOT;
      ST_ROOT: if (rt_bit_r[0]) state_nxt = ST_MULW;
      ST_MULW: state_nxt = ST_DIV;
      ST_DIV:  if (dx_done) state_nxt = ST_EMIT;
      ST_EMIT: if (out_fire && vcnt_r == 3'd5) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state_r == ST_IDLE) && job_valid;
    out_valid = (state_r == ST_EMIT);
    plus      = (vcnt_r == 3'd1) || (vcnt_r == 3'd4) || (vcnt_r == 3'd5);
    far       = (vcnt_r == 3'd2) || (vcnt_r == 3'd3) || (vcnt_r == 3'd5);
    bx        = far ? job_r.p1_x : job_r.p0_x;
    by        = far ? job_r.p1_y : job_r.p0_y;
    bz        = far ? job_r.p1_z : job_r.p0_z;
    out_vert_x       = plus ? bx + wx_r : bx - wx_r;
    out_vert_y       = by;
    out_vert_z       = plus ? bz + wz_r : bz - wz_r;
    out_tex_u        = plus;
    out_fade         = far ? f1_r : f0_r;
    out_last_of_quad = (vcnt_r == 3'd5);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        job_r    <= job_in;
        ax_r     <= dx[32] ? 33'(-dx) : 33'(dx);
        az_r     <= dz[32] ? 33'(-dz) : 33'(dz);
        dx_neg_r <= dx[32];
        dz_pos_r <= !dz[32] && (dz != 33'sd0);
      end
      ST_NORM: begin
        zero_r <= (m == 33'd0);
        if (m[32] || m[31]) begin
          ax_r <= ax_r >> 1;
          az_r <= az_r >> 1;
        end else if (!m[30] && m != 33'd0) begin
          ax_r <= ax_r << 1;
          az_r <= az_r << 1;
        end
        rt_res_r <= '0;
      end
      ST_SQ_A: sum_r <= {2'b0, sq};
      ST_SQ_B: begin
        rt_rem_r <= sum_r + {2'b0, sq};
        rt_res_r <= '0;
        rt_bit_r <= 64'h4000_0000_0000_0000;
      end
      ST_ROOT: begin
        if (rt_ge) begin
          rt_rem_r <= rt_rem_r - rt_try;
          rt_res_r <= (rt_res_r >> 1) + rt_bit_r;
        end else begin
          rt_res_r <= rt_res_r >> 1;
        end
        rt_bit_r <= rt_bit_r >> 2;
      end
      ST_DIV: begin
        if (dx_done) begin
          wx_r <= zero_r ? 32'd0 : (dz_pos_r ? 32'd0 - qx : qx);
          wz_r <= zero_r ? 32'd0 : (dx_neg_r ? 32'd0 - qz : qz);
          f0_r <= FADE_ONE - qf0[16:0];
          f1_r <= FADE_ONE - qf1[16:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r != ST_EMIT) vcnt_r <= '0;
      else if (out_fire) vcnt_r <= (vcnt_r == 3'd5) ? 3'd0 : vcnt_r + 3'd1;
    end
  end

`ifndef ASSERT_OFF
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last_of_quad) |=> !out_valid)
    else $error("emission continued past sixth vertex");
  a_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (vcnt_r == 3'd0))
    else $error("quad emission did not start at first vertex");
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dx_done |-> (dz_done && f0_done && f1_done))
    else $error("dividers out of step");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == ST_NORM))
    else $error("job popped without starting work");
`endif

endmodule

>>> rtl/core/trail_ribbon_vertex_generator_unit.sv
// Trail ribbon vertex generator: polyline points in, ribbon quad vertices out.
//
// Usage: points enter on the in_ channel (valid/stall), one per transaction.
// A point with in_first_of_line opens a line of min(in_line_points, limit)
// points and emits nothing; each later point of the line emits one quad of
// six vertices on the out_ channel (valid/stall), the sixth flagged by
// out_last_of_quad. Points outside an open line are dropped.
// Path of a segment, with the back end idle: the job queue, normalizing
// shifts, the squaring states, the bit-serial square root, the divider start
// and the dividers, then emission of the six vertices; a segment with no
// horizontal extent skips squaring and the square root. The back end works on
// one segment at a time and pops the next job only after the sixth vertex of
// the last has gone out.
// A two-entry job queue lets the input keep accepting while the back end
// works; in_stall rises only while that queue is full.
// When out_stall is high the current vertex holds and the back end waits.
// Reset (synchronous, rst_n low) closes any open line, empties the queue and
// restores segment_limit to 0 (limit 20) and half_width to 0.1.
// Users write configuration registers via cfg_we only while idle; unchecked.
module trail_ribbon_vertex_generator_unit import trvg_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic               in_first_of_line,
  input  logic [15:0]        in_line_points,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_vert_x,
  output logic signed [31:0] out_vert_y,
  output logic signed [31:0] out_vert_z,
  output logic               out_tex_u,
  output logic [16:0]        out_fade,
  output logic               out_last_of_quad
);

  localparam logic [30:0] HW_RESET = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  logic [15:0] seg_limit_r;
  logic [30:0] half_width_r;
  logic        accept;
  logic        push, pop, not_empty, full;
  job_t        wr_job, rd_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_limit_r  <= '0;
      half_width_r <= HW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEG_LIMIT:  seg_limit_r  <= cfg_data[15:0];
        CFG_HALF_WIDTH: half_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  trvg_front u_front (
    .clk, .rst_n, .accept,
    .pos_x(in_pos_x), .pos_y(in_pos_y), .pos_z(in_pos_z),
    .first_of_line(in_first_of_line), .line_points(in_line_points),
    .segment_limit(seg_limit_r), .push, .job(wr_job)
  );

  trvg_fifo u_fifo (
    .clk, .rst_n, .push, .wr_job, .pop, .rd_job, .not_empty, .full
  );

  trvg_back u_back (
    .clk, .rst_n, .half_width(half_width_r),
    .job_valid(not_empty), .job_in(rd_job), .pop,
    .out_valid, .out_stall, .out_vert_x, .out_vert_y, .out_vert_z,
    .out_tex_u, .out_fade, .out_last_of_quad
  );

endmodule
